// File: src/crc15_byte_stream_check_defines.svh
// Assertion macros used by the CRC-15 byte stream check (in cbsc_accum).
// Depends on nothing; a user module must have clk and rst in scope.
`ifndef CRC15_BYTE_STREAM_CHECK_DEFINES_SVH
`define CRC15_BYTE_STREAM_CHECK_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CBSC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cbsc same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define CBSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cbsc next-cycle check failed");

`endif

// File: src/cbsc_pkg.sv
// Types, constants and functions of the CRC-15 byte stream check.
// Used by every module of the block; depends on nothing.
package cbsc_pkg;

  localparam logic [15:0] CRC_POLY         = 16'hC599;
  localparam logic [8:0]  COUNT_MAX        = 9'd511;
  localparam logic [7:0]  MIN_LENGTH_RESET = 8'd3;
  localparam logic [7:0]  MAX_LENGTH_RESET = 8'd16;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_SHORT = 2'd1,
    STATUS_LONG  = 2'd2
  } length_status_t;

  typedef enum logic [0:0] {
    REG_MIN_LENGTH = 1'b0,
    REG_MAX_LENGTH = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic       last_byte;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic           remainder_zero;
    logic [7:0]     check_low;
    logic [7:0]     check_high;
    length_status_t length_status;
  } result_t;

  // Eight steps of the long division, bit 0 of the byte entering first.
  function automatic logic [15:0] divide_byte(input logic [15:0] rem_in,
                                              input logic [7:0] data);
    logic [15:0] rem;
    rem = rem_in;
    for (int i = 0; i < 8; i++) begin
      rem = {rem[14:0], data[i]};
      if (rem[15]) begin
        rem = rem ^ CRC_POLY;
      end
    end
    return rem;
  endfunction

  function automatic logic [7:0] reverse8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7 - i] = v[i];
    end
    return r;
  endfunction

endpackage

// File: src/crc15_byte_stream_check.sv
// CRC-15 (polynomial 0xC599) byte stream check, bits taken LSB first.
// The slave stream carries message bytes with tlast on the final byte of a
// message. Each byte is registered, divided by an unrolled eight-step
// division, and counted (saturating at 511). On the last byte one result
// goes to the master stream: length status against min_length and max_length
// (both counting the two check bytes), the two remainder bytes bit-reversed
// for appending and a flag for a zero remainder (these three are zero when
// the length is out of range). Throughput is one byte per clock while no
// last byte waits for the output register. A result is offered on the master
// side after its last byte passes the input register and the division, and is
// held in the output register until it is taken. Configuration is a plain
// write port: index 0 is min_length (reset 3), index 1 is max_length (reset
// 16); write only while no message is in flight.
// Reset clears the remainder, the count and both valid flags. When the
// receiver stalls, the held result stays; non-last bytes keep flowing until
// a second last byte reaches the division, which then waits and backs up the
// slave side through tready.
module crc15_byte_stream_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] length_status, [9:2] check_high, [17:10] check_low,
  // [18] remainder_zero, [23:19] zero
  output logic [23:0] m_axis_tdata,
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import cbsc_pkg::*;

  item_t   s_item;
  item_t   item;
  logic    item_valid;
  logic    advance;
  logic    out_free;
  logic    res_valid;
  result_t res;
  result_t m_res;

  assign s_item = '{last_byte: s_axis_tlast, data_byte: s_axis_tdata};

  cbsc_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .s_valid    (s_axis_tvalid),
    .s_ready    (s_axis_tready),
    .s_item     (s_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  cbsc_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index_t'(cfg_index)),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .out_free   (out_free),
    .advance    (advance),
    .res_valid  (res_valid),
    .res        (res)
  );

  cbsc_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .m_valid   (m_axis_tvalid),
    .m_ready   (m_axis_tready),
    .m_res     (m_res)
  );

  assign m_axis_tdata = {5'd0, m_res.remainder_zero, m_res.check_low,
                         m_res.check_high, m_res.length_status};

endmodule

// File: src/cbsc_in_reg.sv
// Input register of the CRC-15 byte stream check.
// Depends on cbsc_pkg for the item type.
module cbsc_in_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_valid,
  output logic           s_ready,
  input  cbsc_pkg::item_t s_item,
  input  logic           advance,
  output logic           item_valid,
  output cbsc_pkg::item_t item
);
  import cbsc_pkg::*;

  logic valid;

  // A held item leaves in the same cycle that a new one enters.
  assign s_ready    = !valid || advance;
  assign item_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_valid && s_ready) begin
      valid <= 1'b1;
    end else if (advance) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      item <= s_item;
    end
  end

endmodule

// File: src/cbsc_accum.sv
// Running CRC-15 remainder, saturating byte count, length limits and result
// build of the CRC-15 byte stream check. Depends on cbsc_pkg and the macros.
`include "crc15_byte_stream_check_defines.svh"

module cbsc_accum (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  cbsc_pkg::cfg_index_t cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 item_valid,
  input  cbsc_pkg::item_t      item,
  input  logic                 out_free,
  output logic                 advance,
  output logic                 res_valid,
  output cbsc_pkg::result_t    res
);
  import cbsc_pkg::*;

  logic [7:0]  min_length;
  logic [7:0]  max_length;
  logic [15:0] crc_remainder;
  logic [15:0] crc_remainder_next;
  logic [8:0]  byte_count;
  logic [8:0]  byte_count_next;
  logic [15:0] rem_new;
  logic [8:0]  count_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_length <= MIN_LENGTH_RESET;
      max_length <= MAX_LENGTH_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MIN_LENGTH: min_length <= cfg_data;
        REG_MAX_LENGTH: max_length <= cfg_data;
        default:        ;
      endcase
    end
  end

  // A last byte waits until the output register can take its result.
  assign advance   = item_valid && (!item.last_byte || out_free);
  assign res_valid = advance && item.last_byte;

  assign rem_new   = divide_byte(crc_remainder, item.data_byte);
  assign count_new = (byte_count == COUNT_MAX) ? byte_count : byte_count + 9'd1;

  always_comb begin
    crc_remainder_next = crc_remainder;
    byte_count_next    = byte_count;
    if (advance) begin
      if (item.last_byte) begin
        crc_remainder_next = '0;
        byte_count_next    = '0;
      end else begin
        crc_remainder_next = rem_new;
        byte_count_next    = count_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_remainder <= '0;
      byte_count    <= '0;
    end else begin
      crc_remainder <= crc_remainder_next;
      byte_count    <= byte_count_next;
    end
  end

  // Shortness wins when both limits are violated.
  always_comb begin
    res = '{remainder_zero: 1'b0, check_low: 8'd0, check_high: 8'd0,
            length_status: STATUS_OK};
    if (count_new < {1'b0, min_length}) begin
      res.length_status = STATUS_SHORT;
    end else if (count_new > {1'b0, max_length}) begin
      res.length_status = STATUS_LONG;
    end else begin
      res.check_high     = reverse8(rem_new[15:8]);
      res.check_low      = reverse8(rem_new[7:0]);
      res.remainder_zero = (rem_new == 16'd0);
    end
  end

  `CBSC_ASSERT_NEXT(a_clear_after_last, res_valid, (crc_remainder == 16'd0) && (byte_count == 9'd0))
  `CBSC_ASSERT_IMP(a_bad_length_no_check, res_valid && (res.length_status != STATUS_OK), (res.check_high == 8'd0) && (res.check_low == 8'd0) && !res.remainder_zero)
  `CBSC_ASSERT_IMP(a_top_bit_reduced, 1'b1, !crc_remainder[15])
  `CBSC_ASSERT_IMP(a_result_has_room, res_valid, out_free)

endmodule

// File: src/cbsc_out_reg.sv
// Output register of the CRC-15 byte stream check: holds one result until
// the receiver takes it. Depends on cbsc_pkg for the result type.
module cbsc_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_valid,
  input  cbsc_pkg::result_t res,
  output logic              out_free,
  output logic              m_valid,
  input  logic              m_ready,
  output cbsc_pkg::result_t m_res
);
  import cbsc_pkg::*;

  logic valid;

  assign out_free = !valid || m_ready;
  assign m_valid  = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (res_valid) begin
      valid <= 1'b1;
    end else if (m_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      m_res <= res;
    end
  end

endmodule

// File: verif/crc15_byte_stream_check_tb.sv
// Self-checking testbench for the CRC-15 byte stream check block.
// It drives byte frames with random gaps and receiver stalls, predicts every
// result with its own remainder and length tracker, and needs cbsc_pkg and the RTL.
module crc15_byte_stream_check_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cbsc_pkg::*;

  typedef logic [7:0] byte_queue_t [$];

  localparam int CYCLE_LIMIT   = 200000;
  localparam int GAP_PERCENT   = 17;
  localparam int DRAIN_CYCLES  = 6;
  localparam int RANDOM_ITEMS  = 280;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] data_byte
  logic        s_axis_tlast;   // last_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // [1:0] length_status, [9:2] check_high, [17:10] check_low,
  // [18] remainder_zero, [23:19] zero
  logic [23:0] m_axis_tdata;
  logic        cfg_wr_en;
  logic [0:0]  cfg_index;
  logic [7:0]  cfg_data;

  // Predictor state, mirrored from the block.
  logic [15:0] run_crc = '0;
  logic [8:0]  run_len = '0;
  logic [7:0]  min_len_reg = MIN_LENGTH_RESET;
  logic [7:0]  max_len_reg = MAX_LENGTH_RESET;
  result_t     frame_results_due [$];

  int  mismatches = 0;
  int  cycle_count = 0;
  int  items_sent = 0;
  int  hold_off_cycles = 0;
  bit  sender_gaps = 1'b1;
  bit  receiver_gaps = 1'b1;

  crc15_byte_stream_check dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  // One division pass over a byte, bit 0 first; bit 15 set means subtract.
  function automatic logic [15:0] crc15_step_byte(input logic [15:0] acc,
                                                  input logic [7:0] b);
    logic [15:0] nxt;
    nxt = acc;
    for (int k = 0; k < 8; k++) begin
      nxt = {nxt[14:0], b[k]};
      nxt = nxt[15] ? (nxt ^ CRC_POLY) : nxt;
    end
    return nxt;
  endfunction

  function automatic void note_mismatch(input string field, input int unsigned want,
                                        input int unsigned got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    end
  endfunction

  // Receiver: random stalls, plus a long hold-off when a test asks for one.
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      m_axis_tready = 1'b0;
      hold_off_cycles--;
    end else begin
      m_axis_tready = !(receiver_gaps && $urandom_range(99) < GAP_PERCENT);
    end
  end

  // Predict on every accepted byte and check every accepted result.
  always @(posedge clk) begin
    result_t want;
    result_t got;
    logic [15:0] crc_next;
    logic [8:0]  len_next;
    if (!rst) begin
      if (cfg_wr_en) begin
        if (cfg_index == REG_MIN_LENGTH) begin
          min_len_reg = cfg_data;
        end else begin
          max_len_reg = cfg_data;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        crc_next = crc15_step_byte(run_crc, s_axis_tdata);
        len_next = (run_len == COUNT_MAX) ? run_len : run_len + 9'd1;
        if (s_axis_tlast) begin
          want = '0;
          if (len_next < {1'b0, min_len_reg}) begin
            want.length_status = STATUS_SHORT;
          end else if (len_next > {1'b0, max_len_reg}) begin
            want.length_status = STATUS_LONG;
          end else begin
            want.length_status = STATUS_OK;
            want.check_high = {<<{crc_next[15:8]}};
            want.check_low = {<<{crc_next[7:0]}};
            want.remainder_zero = (crc_next == 16'h0000);
          end
          frame_results_due.push_back(want);
          run_crc = '0;
          run_len = '0;
        end else begin
          run_crc = crc_next;
          run_len = len_next;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[18:0]);
        if (frame_results_due.size() == 0) begin
          note_mismatch("result with no frame pending", 0, m_axis_tdata);
        end else begin
          want = frame_results_due.pop_front();
          if (got.length_status != want.length_status) begin
            note_mismatch("length_status", want.length_status, got.length_status);
          end
          if (got.check_high != want.check_high) begin
            note_mismatch("check_high", want.check_high, got.check_high);
          end
          if (got.check_low != want.check_low) begin
            note_mismatch("check_low", want.check_low, got.check_low);
          end
          if (got.remainder_zero != want.remainder_zero) begin
            note_mismatch("remainder_zero", want.remainder_zero, got.remainder_zero);
          end
          if (m_axis_tdata[23:19] != 5'd0) begin
            note_mismatch("tdata padding", 0, m_axis_tdata[23:19]);
          end
        end
      end
    end
  end

  // Called and returns at a falling edge.
  task automatic send_byte(input logic [7:0] data, input logic last);
    while (sender_gaps && $urandom_range(99) < GAP_PERCENT) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = data;
    s_axis_tlast = last;
    @(posedge clk);
    while (!s_axis_tready) begin
      @(posedge clk);
    end
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    items_sent++;
  endtask

  task automatic send_frame(input byte_queue_t bytes);
    for (int i = 0; i < bytes.size(); i++) begin
      send_byte(bytes[i], i == bytes.size() - 1);
    end
  endtask

  function automatic byte_queue_t random_frame(input int len);
    byte_queue_t q;
    for (int i = 0; i < len; i++) begin
      q.push_back(8'($urandom_range(255)));
    end
    return q;
  endfunction

  // Waits until every result has come back and the pipeline is empty.
  task automatic wait_drained();
    while (frame_results_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_limits(input logic [7:0] lo, input logic [7:0] hi);
    wait_drained();
    cfg_wr_en = 1'b1;
    cfg_index = REG_MIN_LENGTH;
    cfg_data = lo;
    @(negedge clk);
    cfg_index = REG_MAX_LENGTH;
    cfg_data = hi;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Reset limits of 3 and 16: short frames, and ok frames with both data extremes.
  task automatic test_length_status();
    send_frame('{8'hFF});
    send_frame('{8'h00, 8'hFF});
    // The bytes carry the generator itself, so the remainder comes out zero.
    send_frame('{8'h00, 8'hA3, 8'h99});
    send_frame('{8'hFF, 8'hFF, 8'h80});
  endtask

  task automatic test_limit_registers();
    set_limits(8'd0, 8'd4);
    send_frame('{8'h01, 8'h02, 8'h04, 8'h08, 8'h10});
    set_limits(8'd0, 8'd0);
    send_frame('{8'h5A});
    // Both limits violated: shortness wins.
    set_limits(8'd6, 8'd2);
    send_frame('{8'h20, 8'h40, 8'h80, 8'h7F});
  endtask

  // Lengths at and past the byte range, and the count saturating.
  task automatic test_long_frames();
    set_limits(8'd255, 8'd255);
    send_frame(random_frame(255));
    set_limits(8'd0, 8'd255);
    send_frame(random_frame(512));
    send_frame(random_frame(1));
  endtask

  // Receiver holds off while short frames keep coming, so the input backs up.
  task automatic test_receiver_hold_off();
    wait_drained();
    hold_off_cycles = 300;
    repeat (40) begin
      send_frame(random_frame($urandom_range(1, 3)));
    end
  endtask

  task automatic test_random_frames();
    int start_items;
    int phase;
    int len;
    int pick;
    byte_queue_t frame;
    logic [15:0] rem;
    logic [7:0]  chk;
    start_items = items_sent;
    phase = 0;
    while (items_sent - start_items < RANDOM_ITEMS) begin
      pick = $urandom_range(5);
      if (pick == 0) begin
        set_limits(8'd0, 8'd255);
      end else if (pick == 1) begin
        set_limits(8'd255, 8'd0);
      end else if (pick < 5) begin
        set_limits(8'($urandom_range(0, 6)), 8'($urandom_range(2, 20)));
      end
      // One phase runs with no idling on either side.
      sender_gaps = (phase != 3);
      receiver_gaps = (phase != 3);
      repeat ($urandom_range(4, 12)) begin
        len = ($urandom_range(99) < 5) ? $urandom_range(23, 70) : $urandom_range(1, 22);
        frame = random_frame(len);
        pick = $urandom_range(15);
        if (pick == 0) begin
          foreach (frame[i]) frame[i] = 8'h00;
        end else if (pick < 3) begin
          rem = '0;
          foreach (frame[i]) rem = crc15_step_byte(rem, frame[i]);
          chk = {<<{rem[15:8]}};
          frame.push_back(chk);
          chk = {<<{rem[7:0]}};
          frame.push_back(chk);
        end
        send_frame(frame);
      end
      phase++;
    end
    sender_gaps = 1'b1;
    receiver_gaps = 1'b1;
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_MIN_LENGTH;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_length_status();
    test_limit_registers();
    test_long_frames();
    test_receiver_hold_off();
    test_random_frames();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && frame_results_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
